// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int LIMIT_W   = 9;
    localparam int FIELD_W   = 32;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pri;
        logic signed [FIELD_W-1:0] id;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

// ===== rtl/max_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top
// Binary max-heap of (id, priority) entries with insert and remove requests.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_*       in   s_tvalid / s_tready     tuser: func; tdata: item_id, item_priority
// m_*       out  m_tvalid / m_tready     tuser: status; tdata: out_id, out_priority
// cfg_*     in   cfg_wr_en               cfg_wr_data: capacity_limit
//
// An insert walks up the heap and a remove walks down it, one level at a time;
// a full insert or an empty remove goes straight to the result. Each level is a
// registered memory read followed by one compare. s_tready is low while a
// request is in work; a result waiting in the output register holds the request
// in S_DONE until it is taken, and so blocks the next request. Reset empties
// the heap and sets the limit to 256; memory contents are left as they are.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top
    import mhpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [0:0]           s_tuser,    // [0] func
    input  logic [2*FIELD_W-1:0] s_tdata,    // [31:0] item_id, [63:32] item_priority
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [1:0]           m_tuser,    // [1:0] status
    output logic [2*FIELD_W-1:0] m_tdata,    // [31:0] out_id, [63:32] out_priority
    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int KW = AW + 2;

    entry_t heap_mem [DEPTH];

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [AW-1:0]       pos_reg, pos_next;
    entry_t              cur_reg, cur_next;
    status_t             res_status_reg, res_status_next;
    entry_t              res_entry_reg, res_entry_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    entry_t              out_entry_reg, out_entry_next;

    logic [AW-1:0]       rd_a_addr, rd_b_addr;
    entry_t              rd_a_reg, rd_b_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    entry_t              mem_wdata;

    logic                accept;
    logic                is_full;
    logic [LW-1:0]       lim_eff;
    logic [CW-1:0]       count_dec;
    logic [AW-1:0]       parent;
    logic [KW-1:0]       lchild, rchild, count_ext;
    logic                l_ok, r_ok;
    entry_t              best_l;
    entry_t              req_entry;
    logic                out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign req_entry = s_tdata;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = out_entry_reg;
    assign out_free  = !out_valid_reg || m_tready;

    assign lim_eff   = (LW'(limit_reg) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(limit_reg);
    assign is_full   = LW'(count_reg) >= lim_eff;
    assign count_dec = count_reg - CW'(1);
    assign parent    = AW'(pos_reg - AW'(1)) >> 1;
    assign lchild    = KW'({pos_reg, 1'b1});
    assign rchild    = {({1'b0, pos_reg} + (AW+1)'(1)), 1'b0};
    assign count_ext = KW'(count_reg);

    // sift-down choice: left only if strictly above the moving entry,
    // right only if strictly above the left choice
    assign l_ok   = (lchild < count_ext) && (cur_reg.pri < rd_a_reg.pri);
    assign best_l = l_ok ? rd_a_reg : cur_reg;
    assign r_ok   = (rchild < count_ext) && (best_l.pri < rd_b_reg.pri);

    // heap memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[rd_b_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == FUNC_INSERT)
                        state_next = is_full ? S_DONE : S_UP_CHK;
                    else
                        state_next = (count_reg == '0) ? S_DONE : S_DN_LOAD;
                end
            end
            S_UP_CHK:  state_next = (pos_reg == '0) ? S_DONE : S_UP_CMP;
            S_UP_CMP:  state_next = (rd_a_reg.pri < cur_reg.pri) ? S_UP_CHK : S_DONE;
            S_DN_LOAD: state_next = S_DN_RD;
            S_DN_RD:   state_next = S_DN_CMP;
            S_DN_CMP:  state_next = (l_ok || r_ok) ? S_DN_RD : S_DONE;
            S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        rd_a_addr       = '0;
        rd_b_addr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = cur_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_a_addr = '0;
                rd_b_addr = count_dec[AW-1:0];
                if (accept)
                begin
                    res_entry_next = '0;
                    if (s_tuser[0] == FUNC_INSERT)
                    begin
                        res_status_next = is_full ? ST_FULL : ST_INSERTED;
                        if (!is_full)
                        begin
                            cur_next   = req_entry;
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        res_status_next = (count_reg == '0) ? ST_EMPTY : ST_REMOVED;
                        if (count_reg != '0)
                            count_next = count_dec;
                    end
                end
            end
            S_UP_CHK:
            begin
                rd_a_addr = parent;
                if (pos_reg == '0)
                    mem_we = 1'b1;
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (rd_a_reg.pri < cur_reg.pri)
                begin
                    mem_wdata = rd_a_reg;
                    pos_next  = parent;
                end
            end
            S_DN_LOAD:
            begin
                res_entry_next = rd_a_reg;
                cur_next       = rd_b_reg;
                pos_next       = '0;
            end
            S_DN_RD:
            begin
                rd_a_addr = lchild[AW-1:0];
                rd_b_addr = rchild[AW-1:0];
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (r_ok)
                begin
                    mem_wdata = rd_b_reg;
                    pos_next  = rchild[AW-1:0];
                end
                else if (l_ok)
                begin
                    mem_wdata = rd_a_reg;
                    pos_next  = lchild[AW-1:0];
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_entry_next  = res_entry_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            limit_reg     <= LIMIT_W'(256);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
    end

endmodule
